// File: rtl/core/tftm_pkg.sv
// Shared constants, types and codes of the trigger frame timestamp matcher.
`default_nettype none
package tftm_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int LIMIT_W     = 5;
	localparam int LIM_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int ID_W        = 16;
	localparam int TIME_W      = 63;
	localparam int SEQ_W       = 32;
	localparam int CTR_W       = 32;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = LIMIT_W;

	localparam logic [ID_W-1:0] ID_MAX = 16'hFFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LIMIT = 1'd1;

	localparam logic               SYNC_ENABLE_RST = 1'b1;
	localparam logic [LIMIT_W-1:0] TABLE_LIMIT_RST = 5'd20;

	localparam logic CMD_TRIGGER = 1'b0;

	typedef enum logic [1:0] {
		OP_STORE,
		OP_EVICT,
		OP_TAKE
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CAL,
		ST_FID,
		ST_DROP,
		ST_WAIT,
		ST_INSERT,
		ST_CHECK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              valid;
		op_t               op;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] ts;
		logic [LIM_W-1:0]  half;
		logic              found;
		logic              free_found;
		logic [IDX_W-1:0]  free_idx;
		logic [IDX_W-1:0]  pos;
		logic [CNT_W-1:0]  evicted;
	} tok_t;

endpackage
`default_nettype wire

// File: rtl/core/tftm_in_if.sv
// Input channel: trigger events and frame arrivals.
`default_nettype none
interface tftm_in_if
	import tftm_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              command;
	logic [ID_W-1:0]   trigger_id;
	logic [TIME_W-1:0] trigger_stamp;
	logic [SEQ_W-1:0]  capture_sequence;

	modport source (output valid, command, trigger_id, trigger_stamp, capture_sequence,
		input ready);
	modport sink (input valid, command, trigger_id, trigger_stamp, capture_sequence,
		output ready);
endinterface
`default_nettype wire

// File: rtl/core/tftm_out_if.sv
// Output channel: one result per frame arrival.
`default_nettype none
interface tftm_out_if
	import tftm_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   frame_number;
	logic              matched;
	logic [TIME_W-1:0] frame_stamp;
	logic [ID_W-1:0]   drops_now;
	logic [CTR_W-1:0]  drop_total;
	logic [CTR_W-1:0]  received_total;
	logic [CTR_W-1:0]  matched_total;

	modport source (output valid, frame_number, matched, frame_stamp, drops_now, drop_total,
		received_total, matched_total, input ready);
	modport sink (input valid, frame_number, matched, frame_stamp, drops_now, drop_total,
		received_total, matched_total, output ready);
endinterface
`default_nettype wire

// File: rtl/core/tftm_cell.sv
// One table entry of the chain; checks the passing token and forwards it.
`default_nettype none
module tftm_cell
	import tftm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tok_t              tok_in,
	output tok_t                   tok_out,
	input  wire logic              ins_en,
	input  wire logic [ID_W-1:0]   ins_key,
	input  wire logic [TIME_W-1:0] ins_ts
);

	logic              v_q;
	logic [ID_W-1:0]   key_q;
	logic [TIME_W-1:0] ts_q;
	tok_t              tok_q;
	tok_t              tok_d;
	logic [ID_W-1:0]   age;
	logic              hit;
	logic              stale;
	logic              upd_ts;
	logic              clr;

	always_comb begin
		age    = tok_in.id - key_q;
		hit    = tok_in.valid && v_q && (key_q == tok_in.id);
		stale  = tok_in.valid && v_q && (age > {{(ID_W-LIM_W){1'b0}}, tok_in.half});
		upd_ts = 1'b0;
		clr    = 1'b0;
		tok_d  = tok_in;
		tok_d.pos = tok_in.pos + IDX_W'(1);
		case (tok_in.op)
			OP_STORE: begin
				if (hit && !tok_in.found) begin
					tok_d.found = 1'b1;
					upd_ts      = 1'b1;
				end
				if (tok_in.valid && !v_q && !tok_in.free_found) begin
					tok_d.free_found = 1'b1;
					tok_d.free_idx   = tok_in.pos;
				end
			end
			OP_EVICT: begin
				if (stale) begin
					tok_d.evicted = tok_in.evicted + CNT_W'(1);
					clr           = 1'b1;
				end
			end
			OP_TAKE: begin
				if (hit && !tok_in.found) begin
					tok_d.found = 1'b1;
					tok_d.ts    = ts_q;
					clr         = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= 1'b0;
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
			if (ins_en) begin
				v_q <= 1'b1;
			end else if (clr) begin
				v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en) begin
			key_q <= ins_key;
			ts_q  <= ins_ts;
		end else if (upd_ts) begin
			ts_q <= tok_in.ts;
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

// File: rtl/core/trigger_frame_timestamp_matcher.sv
// Top level: controller and the chain of table cells of the timestamp matcher.
// The table is a row of TABLE_DEPTH cells; every lookup is a token that moves one cell per
// cycle through the row. A trigger event makes a store pass, inserts its id into a free
// cell when the id is not yet stored, and is followed by an eviction pass when the table
// is over its limit. A frame arrival makes a take pass with sync enabled and skips the
// table with it disabled; one item is processed at a time and the result waits in an
// output register. Entry valid bits clear at reset, so no clearing pass is needed.
`default_nettype none
module trigger_frame_timestamp_matcher
	import tftm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	tftm_in_if.sink                    req,
	tftm_out_if.source                 rsp
);

	state_t            state_q;
	state_t            state_d;
	logic              sync_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ID_W-1:0]   latest_q;
	logic              cal_q;
	logic [SEQ_W-1:0]  offset_q;
	logic [CTR_W-1:0]  drop_cnt_q;
	logic [CTR_W-1:0]  recv_cnt_q;
	logic [CTR_W-1:0]  match_cnt_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] ts_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [ID_W-1:0]   fid_q;
	logic [ID_W-1:0]   drops_q;
	logic              hit_q;
	logic [TIME_W-1:0] ftime_q;
	logic [IDX_W-1:0]  ins_idx_q;
	tok_t              launch_q;
	tok_t              launch_d;
	logic              out_v_q;
	logic [ID_W-1:0]   o_fid_q;
	logic              o_hit_q;
	logic [TIME_W-1:0] o_time_q;
	logic [ID_W-1:0]   o_drops_q;
	logic [CTR_W-1:0]  o_drop_q;
	logic [CTR_W-1:0]  o_recv_q;
	logic [CTR_W-1:0]  o_match_q;

	tok_t              tok_c [0:TABLE_DEPTH];
	tok_t              tok_ret;
	logic              ins_en;
	logic              out_free;
	logic [LIM_W-1:0]  lim_eff;
	logic              over;
	logic [ID_W-1:0]   expect_id;
	logic [ID_W-1:0]   drops;

	assign tok_c[0] = launch_q;
	assign tok_ret  = tok_c[TABLE_DEPTH];

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic sel;
		assign sel = ins_en && (ins_idx_q == IDX_W'(i));
		tftm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok_c[i]),
			.tok_out (tok_c[i+1]),
			.ins_en  (sel),
			.ins_key (id_q),
			.ins_ts  (ts_q)
		);
	end

	always_comb begin
		out_free = !out_v_q || rsp.ready;
		if (LIM_W'(limit_q) > LIM_W'(TABLE_DEPTH - 1)) begin
			lim_eff = LIM_W'(TABLE_DEPTH - 1);
		end else begin
			lim_eff = LIM_W'(limit_q);
		end
		over      = LIM_W'(cnt_q) > lim_eff;
		expect_id = latest_q + ID_W'(1);
		if (fid_q > expect_id) begin
			drops = fid_q - expect_id;
		end else if (fid_q == '0 && expect_id == ID_MAX) begin
			drops = ID_W'(1);
		end else begin
			drops = '0;
		end
	end

	always_comb begin
		launch_d = '0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid && req.command == CMD_TRIGGER) begin
					launch_d.valid = 1'b1;
					launch_d.op    = OP_STORE;
					launch_d.id    = req.trigger_id;
					launch_d.ts    = req.trigger_stamp;
				end
			end
			ST_DROP: begin
				launch_d.valid = 1'b1;
				launch_d.op    = OP_TAKE;
				launch_d.id    = fid_q;
			end
			ST_CHECK: begin
				if (over) begin
					launch_d.valid = 1'b1;
					launch_d.op    = OP_EVICT;
					launch_d.id    = id_q;
					launch_d.half  = lim_eff >> 1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (req.command == CMD_TRIGGER) begin
						state_d = ST_WAIT;
					end else begin
						state_d = sync_q ? ST_CAL : ST_FID;
					end
				end
			end
			ST_CAL:    state_d = ST_FID;
			ST_FID:    state_d = sync_q ? ST_DROP : ST_FINISH;
			ST_DROP:   state_d = ST_WAIT;
			ST_WAIT: begin
				if (tok_ret.valid) begin
					case (tok_ret.op)
						OP_STORE: begin
							state_d = (!tok_ret.found && tok_ret.free_found) ? ST_INSERT
								: ST_CHECK;
						end
						OP_EVICT: state_d = ST_IDLE;
						OP_TAKE:  state_d = ST_FINISH;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_INSERT: state_d = ST_CHECK;
			ST_CHECK:  state_d = over ? ST_WAIT : ST_IDLE;
			ST_FINISH: state_d = out_free ? ST_IDLE : ST_FINISH;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == ST_IDLE);
		rsp.valid = out_v_q;
		ins_en    = (state_q == ST_INSERT);
	end

	assign rsp.frame_number   = o_fid_q;
	assign rsp.matched        = o_hit_q;
	assign rsp.frame_stamp    = o_time_q;
	assign rsp.drops_now      = o_drops_q;
	assign rsp.drop_total     = o_drop_q;
	assign rsp.received_total = o_recv_q;
	assign rsp.matched_total  = o_match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sync_q      <= SYNC_ENABLE_RST;
			limit_q     <= TABLE_LIMIT_RST;
			cnt_q       <= '0;
			latest_q    <= '0;
			cal_q       <= 1'b0;
			offset_q    <= '0;
			drop_cnt_q  <= '0;
			recv_cnt_q  <= '0;
			match_cnt_q <= '0;
			launch_q    <= '0;
			out_v_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= launch_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_SYNC_ENABLE: sync_q  <= cfg_data[0];
					CFG_TABLE_LIMIT: limit_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ST_FINISH && out_free) begin
				out_v_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						if (req.command == CMD_TRIGGER) begin
							latest_q <= req.trigger_id;
						end else begin
							recv_cnt_q <= recv_cnt_q + CTR_W'(1);
						end
					end
				end
				ST_CAL: begin
					if (!cal_q && latest_q != '0) begin
						offset_q <= {{(SEQ_W-ID_W){1'b0}}, latest_q} - seq_q;
						cal_q    <= 1'b1;
					end
				end
				ST_DROP: begin
					if (latest_q != '0 && cal_q) begin
						drop_cnt_q <= drop_cnt_q + {{(CTR_W-ID_W){1'b0}}, drops};
					end
				end
				ST_WAIT: begin
					if (tok_ret.valid) begin
						case (tok_ret.op)
							OP_EVICT: cnt_q <= cnt_q - tok_ret.evicted;
							OP_TAKE: begin
								if (tok_ret.found) begin
									cnt_q <= cnt_q - CNT_W'(1);
									if (tok_ret.ts != '0) begin
										match_cnt_q <= match_cnt_q + CTR_W'(1);
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_INSERT: cnt_q <= cnt_q + CNT_W'(1);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				id_q    <= req.trigger_id;
				ts_q    <= req.trigger_stamp;
				seq_q   <= req.capture_sequence;
				drops_q <= '0;
				hit_q   <= 1'b0;
				ftime_q <= '0;
			end
			ST_FID: begin
				if (sync_q) begin
					fid_q <= seq_q[ID_W-1:0] + offset_q[ID_W-1:0];
				end else begin
					fid_q <= seq_q[ID_W-1:0];
				end
			end
			ST_DROP: begin
				if (latest_q != '0 && cal_q) begin
					drops_q <= drops;
				end
			end
			ST_WAIT: begin
				if (tok_ret.valid && tok_ret.op == OP_STORE) begin
					ins_idx_q <= tok_ret.free_idx;
				end
				if (tok_ret.valid && tok_ret.op == OP_TAKE && tok_ret.found
					&& tok_ret.ts != '0) begin
					hit_q   <= 1'b1;
					ftime_q <= tok_ret.ts;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					o_fid_q   <= fid_q;
					o_hit_q   <= hit_q;
					o_time_q  <= ftime_q;
					o_drops_q <= drops_q;
					o_drop_q  <= drop_cnt_q;
					o_recv_q  <= recv_cnt_q;
					o_match_q <= match_cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	a_tok_return: assert property (@(posedge clk) disable iff (!arst_n)
		tok_ret.valid |-> state_q == ST_WAIT)
		else $error("token returned outside wait state");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INSERT |-> cnt_q < CNT_W'(TABLE_DEPTH))
		else $error("insert into a full table");

	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		cal_q |=> cal_q)
		else $error("calibration lost");

endmodule
`default_nettype wire
